@@ src/smrp_pkg.sv @@
package smrp_pkg;

    localparam logic [7:0] CH_ESC    = 8'h1b;
    localparam logic [7:0] CH_LBRACK = 8'h5b;
    localparam logic [7:0] CH_LT     = 8'h3c;
    localparam logic [7:0] CH_SEMI   = 8'h3b;
    localparam logic [7:0] CH_PRESS  = 8'h4d;
    localparam logic [7:0] CH_REL    = 8'h6d;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [3:0] MIN_BYTES = 4'd8;

    typedef enum logic [2:0] {
        PH_ESC   = 3'd0,
        PH_BRACK = 3'd1,
        PH_LT    = 3'd2,
        PH_BTN   = 3'd3,
        PH_X     = 3'd4,
        PH_Y     = 3'd5,
        PH_DONE  = 3'd6,
        PH_FAIL  = 3'd7
    } t_phase;

    typedef struct packed {
        logic [7:0] key_byte;
        logic       buffer_end;
    } t_in_item;

    typedef struct packed {
        logic               event_valid;
        logic [7:0]         button_code;
        logic signed [15:0] column;
        logic signed [15:0] row;
        logic               pressed;
    } t_out_item;

endpackage

@@ src/sgr_mouse_report_parser.sv @@
// SGR mouse report parser.
// The input channel carries one byte of a key buffer per transaction, with
// buffer_end set on the buffer's last byte. The output channel carries one
// result transaction per buffer, sent after its last byte, with event_valid
// set when the buffer held ESC [ < button ; x ; y followed by M or m and was
// at least eight bytes long; otherwise all result fields are zero.
// A byte is taken into an input register, parsed from there by one
// compare and multiply-by-ten step, and the result lands in the output
// register. One byte is accepted in every cycle unless a buffer's last
// byte is waiting, as set by the single parse step.
// When the receiver stalls, bytes that do not end a buffer keep flowing;
// a buffer's last byte waits in the input register until the output
// register is free, and input ready stays low while it waits.
// Synchronous active-low reset empties both registers and returns the
// parser to expecting the escape byte.
module sgr_mouse_report_parser
    import smrp_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_data
);

    logic      out_free;
    logic      step;
    t_in_item  item;
    t_out_item result;

    smrp_in_reg u_in_reg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .i_out_free (out_free),
        .o_step     (step),
        .o_item     (item)
    );

    smrp_parse_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_item   (item),
        .o_result (result)
    );

    smrp_out_reg u_out_reg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (step && item.buffer_end),
        .i_result    (result),
        .o_free      (out_free),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

@@ src/smrp_in_reg.sv @@
module smrp_in_reg
    import smrp_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_in_item i_in_data,
    input  logic     i_out_free,
    output logic     o_step,
    output t_in_item o_item
);

    logic     r_valid;
    t_in_item r_data;

    // A byte that ends a buffer moves on only when the result register can take it.
    assign o_step     = r_valid && (!r_data.buffer_end || i_out_free);
    assign o_in_ready = !r_valid || o_step;
    assign o_item     = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_data <= i_in_data;
        end
    end

endmodule

@@ src/smrp_parse_core.sv @@
module smrp_parse_core
    import smrp_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_step,
    input  t_in_item  i_item,
    output t_out_item o_result
);

    t_phase      r_phase;
    logic [3:0]  r_count;
    logic [7:0]  r_button;
    logic [15:0] r_column;
    logic [15:0] r_row;
    logic        r_pressed;

    t_phase      n_phase;
    logic [3:0]  n_count;
    logic [7:0]  n_button;
    logic [15:0] n_column;
    logic [15:0] n_row;
    logic        n_pressed;

    t_phase      step_phase;
    logic [3:0]  step_count;
    logic [7:0]  step_button;
    logic [15:0] step_column;
    logic [15:0] step_row;
    logic        step_pressed;

    logic [7:0]  fold_button;
    logic [15:0] fold_column;
    logic [15:0] fold_row;
    logic [7:0]  b;

    assign b = i_item.key_byte;

    // Every byte in a number field other than its terminator is folded in as a decimal digit, wrapping.
    assign fold_button = r_button * 8'd10 + b - CH_ZERO;
    assign fold_column = r_column * 16'd10 + {8'd0, b} - {8'd0, CH_ZERO};
    assign fold_row    = r_row * 16'd10 + {8'd0, b} - {8'd0, CH_ZERO};

    always_comb begin
        step_phase = r_phase;
        unique case (r_phase)
            PH_ESC:   step_phase = (b == CH_ESC) ? PH_BRACK : PH_FAIL;
            PH_BRACK: step_phase = (b == CH_LBRACK) ? PH_LT : PH_FAIL;
            PH_LT:    step_phase = (b == CH_LT) ? PH_BTN : PH_FAIL;
            PH_BTN:   step_phase = (b == CH_SEMI) ? PH_X : PH_BTN;
            PH_X:     step_phase = (b == CH_SEMI) ? PH_Y : PH_X;
            PH_Y:     step_phase = (b == CH_PRESS || b == CH_REL) ? PH_DONE : PH_Y;
            PH_DONE:  step_phase = PH_DONE;
            PH_FAIL:  step_phase = PH_FAIL;
            default:  step_phase = PH_FAIL;
        endcase
        n_phase = i_item.buffer_end ? PH_ESC : step_phase;
    end

    always_comb begin
        step_count   = (r_count < MIN_BYTES) ? r_count + 4'd1 : r_count;
        step_button  = r_button;
        step_column  = r_column;
        step_row     = r_row;
        step_pressed = r_pressed;
        unique case (r_phase)
            PH_BTN: begin
                if (b != CH_SEMI) step_button = fold_button;
            end
            PH_X: begin
                if (b != CH_SEMI) step_column = fold_column;
            end
            PH_Y: begin
                if (b == CH_PRESS || b == CH_REL) begin
                    step_pressed = (b == CH_PRESS);
                end else begin
                    step_row = fold_row;
                end
            end
            default: begin
            end
        endcase

        if (i_item.buffer_end) begin
            n_count   = 4'd0;
            n_button  = 8'd0;
            n_column  = 16'd0;
            n_row     = 16'd0;
            n_pressed = 1'b0;
        end else begin
            n_count   = step_count;
            n_button  = step_button;
            n_column  = step_column;
            n_row     = step_row;
            n_pressed = step_pressed;
        end

        o_result = '0;
        if (step_phase == PH_DONE && step_count >= MIN_BYTES) begin
            o_result.event_valid = 1'b1;
            o_result.button_code = step_button;
            o_result.column      = $signed(step_column);
            o_result.row         = $signed(step_row);
            o_result.pressed     = step_pressed;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_ESC;
            r_count   <= 4'd0;
            r_button  <= 8'd0;
            r_column  <= 16'd0;
            r_row     <= 16'd0;
            r_pressed <= 1'b0;
        end else if (i_step) begin
            r_phase   <= n_phase;
            r_count   <= n_count;
            r_button  <= n_button;
            r_column  <= n_column;
            r_row     <= n_row;
            r_pressed <= n_pressed;
        end
    end

endmodule

@@ src/smrp_out_reg.sv @@
module smrp_out_reg
    import smrp_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_load,
    input  t_out_item i_result,
    output logic      o_free,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_data
);

    logic      r_valid;
    t_out_item r_data;

    assign o_free      = !r_valid || i_out_ready;
    assign o_out_valid = r_valid;
    assign o_out_data  = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_data <= i_result;
        end
    end

endmodule

@@ tb/sgr_report_checker.sv @@
`timescale 1ns / 1ps

module sgr_report_checker
    import smrp_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_in_ready,
    input  t_in_item  i_in_data,
    input  logic      i_out_valid,
    input  logic      i_out_ready,
    input  t_out_item i_out_data,
    output int        o_fail_count,
    output int        o_pending
);

    t_phase      phase;
    logic [3:0]  key_count;
    logic [7:0]  button_sum;
    logic [15:0] column_sum;
    logic [15:0] row_sum;
    logic        press_flag;
    t_out_item   expected_reports[$];
    int          errors;

    initial begin
        errors = 0;
    end

    task clear_parser();
        phase      = PH_ESC;
        key_count  = 4'd0;
        button_sum = 8'd0;
        column_sum = 16'd0;
        row_sum    = 16'd0;
        press_flag = 1'b0;
    endtask

    task decode_key_byte(input t_in_item item);
        logic [7:0] kb;
        t_out_item  report;
        kb = item.key_byte;
        if (key_count < MIN_BYTES) begin
            key_count = key_count + 4'd1;
        end
        case (phase)
            PH_ESC: begin
                phase = (kb == CH_ESC) ? PH_BRACK : PH_FAIL;
            end
            PH_BRACK: begin
                phase = (kb == CH_LBRACK) ? PH_LT : PH_FAIL;
            end
            PH_LT: begin
                phase = (kb == CH_LT) ? PH_BTN : PH_FAIL;
            end
            PH_BTN: begin
                if (kb == CH_SEMI) begin
                    phase = PH_X;
                end else begin
                    button_sum = button_sum * 8'd10 + kb - CH_ZERO;
                end
            end
            PH_X: begin
                if (kb == CH_SEMI) begin
                    phase = PH_Y;
                end else begin
                    column_sum = column_sum * 16'd10 + {8'd0, kb} - {8'd0, CH_ZERO};
                end
            end
            PH_Y: begin
                if (kb == CH_PRESS || kb == CH_REL) begin
                    press_flag = (kb == CH_PRESS);
                    phase      = PH_DONE;
                end else begin
                    row_sum = row_sum * 16'd10 + {8'd0, kb} - {8'd0, CH_ZERO};
                end
            end
            default: begin
            end
        endcase
        if (item.buffer_end) begin
            report = '0;
            if (phase == PH_DONE && key_count >= MIN_BYTES) begin
                report.event_valid = 1'b1;
                report.button_code = button_sum;
                report.column      = column_sum;
                report.row         = row_sum;
                report.pressed     = press_flag;
            end
            expected_reports.push_back(report);
            clear_parser();
        end
    endtask

    task check_report(input t_out_item got);
        t_out_item want;
        if (expected_reports.size() == 0) begin
            errors++;
            $display("%0t: unexpected result, actual %h", $time, got);
        end else begin
            want = expected_reports.pop_front();
            if (got.event_valid !== want.event_valid) begin
                errors++;
                $display("%0t: event_valid mismatch, expected %0d, actual %0d",
                         $time, want.event_valid, got.event_valid);
            end
            if (got.button_code !== want.button_code) begin
                errors++;
                $display("%0t: button_code mismatch, expected %0d, actual %0d",
                         $time, want.button_code, got.button_code);
            end
            if (got.column !== want.column) begin
                errors++;
                $display("%0t: column mismatch, expected %0d, actual %0d",
                         $time, want.column, got.column);
            end
            if (got.row !== want.row) begin
                errors++;
                $display("%0t: row mismatch, expected %0d, actual %0d",
                         $time, want.row, got.row);
            end
            if (got.pressed !== want.pressed) begin
                errors++;
                $display("%0t: pressed mismatch, expected %0d, actual %0d",
                         $time, want.pressed, got.pressed);
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_parser();
            expected_reports.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                check_report(i_out_data);
            end
            if (i_in_valid && i_in_ready) begin
                decode_key_byte(i_in_data);
            end
        end
        o_fail_count <= errors;
        o_pending    <= expected_reports.size();
    end

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
    import smrp_pkg::*;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      in_valid    = 1'b0;
    t_in_item  in_data     = '0;
    logic      out_ready   = 1'b0;
    logic      o_in_ready;
    logic      o_out_valid;
    t_out_item o_out_data;
    int        fail_count;
    int        pending;

    logic [7:0] key_q[$];
    bit         send_calm = 1'b0;
    bit         recv_calm = 1'b0;
    int         bytes_sent = 0;

    sgr_mouse_report_parser u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (o_out_data)
    );

    sgr_report_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (o_in_ready),
        .i_in_data    (in_data),
        .i_out_valid  (o_out_valid),
        .i_out_ready  (out_ready),
        .i_out_data   (o_out_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #2000000;
        $display("FAIL");
        $finish;
    end

    task send_key(input logic [7:0] kb, input logic last);
        int       gap;
        t_in_item item;
        if ($urandom_range(0, 49) == 0) begin
            send_calm = !send_calm;
        end
        gap = send_calm ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        item.key_byte   = kb;
        item.buffer_end = last;
        in_valid <= 1'b1;
        in_data  <= item;
        do @(posedge i_clk); while (!o_in_ready);
        bytes_sent++;
    endtask

    task send_buffer();
        for (int i = 0; i < key_q.size(); i++) begin
            send_key(key_q[i], i == key_q.size() - 1);
        end
    endtask

    task add_number(input int digits, input bit noisy);
        for (int i = 0; i < digits; i++) begin
            if (noisy && $urandom_range(0, 3) == 0) begin
                key_q.push_back(8'($urandom_range(0, 255)));
            end else begin
                key_q.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
            end
        end
    endtask

    task build_report(input bit noisy);
        key_q.delete();
        key_q.push_back(CH_ESC);
        key_q.push_back(CH_LBRACK);
        key_q.push_back(CH_LT);
        add_number($urandom_range(0, 5), noisy);
        key_q.push_back(CH_SEMI);
        add_number($urandom_range(0, 5), noisy);
        key_q.push_back(CH_SEMI);
        add_number($urandom_range(0, 5), noisy);
        key_q.push_back($urandom_range(0, 1) ? CH_PRESS : CH_REL);
        repeat ($urandom_range(0, 2)) key_q.push_back(8'($urandom_range(0, 255)));
    endtask

    initial begin
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            int stall;
            if ($urandom_range(0, 29) == 0) begin
                recv_calm = !recv_calm;
            end
            stall = recv_calm ? 0 : $urandom_range(0, 10);
            if (stall > 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    initial begin
        int kind;
        int cut;
        int waited;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Press report followed by a trailing byte that must be ignored.
        key_q = '{CH_ESC, CH_LBRACK, CH_LT, CH_ZERO, CH_SEMI, 8'h31, CH_SEMI,
                  8'h32, CH_PRESS, 8'hff};
        send_buffer();
        // Release report that is well formed but too short.
        key_q = '{CH_ESC, CH_LBRACK, CH_LT, CH_SEMI, CH_SEMI, CH_REL};
        send_buffer();
        // A single byte that breaks the prefix.
        key_q = '{8'h00};
        send_buffer();
        // A press letter inside the button field, and the buffer ends inside y.
        key_q = '{CH_ESC, CH_LBRACK, CH_LT, CH_PRESS, CH_SEMI, CH_SEMI, 8'h35, 8'h39};
        send_buffer();

        while (bytes_sent < 1700) begin
            kind = $urandom_range(0, 99);
            if (kind < 85) begin
                build_report(kind < 10);
                if (kind >= 70 && kind < 78) begin
                    key_q[$urandom_range(0, key_q.size() - 1)] = 8'($urandom_range(0, 255));
                end else if (kind >= 78) begin
                    cut = $urandom_range(1, key_q.size() - 1);
                    while (key_q.size() > cut) void'(key_q.pop_back());
                end
            end else begin
                key_q.delete();
                if ($urandom_range(0, 1) == 0) begin
                    key_q.push_back(CH_ESC);
                end
                repeat ($urandom_range(1, 12)) key_q.push_back(8'($urandom_range(0, 255)));
            end
            send_buffer();
        end
        in_valid <= 1'b0;

        waited = 0;
        while (pending != 0 && waited < 2000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (10) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

@@ sim.f @@
src/smrp_pkg.sv
src/smrp_in_reg.sv
src/smrp_parse_core.sv
src/smrp_out_reg.sv
src/sgr_mouse_report_parser.sv
tb/sgr_report_checker.sv
tb/testbench.sv
